[rtl/core/i2rd_pkg.sv]
// Shared types, constants and helpers for the integer to radix digit converter.
package i2rd_pkg;

    localparam int BASE_W    = 5;   // base field width
    localparam int DIGIT_W   = 4;   // one stored digit, 0..15
    localparam int CHAR_W    = 7;   // ASCII character width
    localparam int STEP_BITS = 8;   // dividend bits retired per divider cycle

    localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'd65;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_LOAD
    } t_state;

    // Digit value 0..15 to '0'-'9' / 'A'-'F'.
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d < 4'd10) begin
            res = ASCII_ZERO + CHAR_W'(d);
        end else begin
            res = ASCII_A + CHAR_W'(d - 4'd10);
        end
        return res;
    endfunction

endpackage

[rtl/core/integer_to_radix_digits.sv]
// Top level: unsigned integer to ASCII digit stream in a radix from 2 to 16.
// Division: one division per digit, by the shared 8-bit-per-cycle restoring divide
//   step over the byte-padded dividend.
// Emission: each digit passes ST_READ then ST_LOAD through the registered digit store
//   read port; ST_LOAD waits while the output word is not taken. A new value is accepted only in idle.
// Reset: i_rst_n synchronous, active low; clears control, store contents undefined.
module integer_to_radix_digits #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // input word: [VALUE_WIDTH-1:0] value, [VALUE_WIDTH+4:VALUE_WIDTH] base, zero pad
    input  logic                                          i_s_tvalid,
    output logic                                          o_s_tready,
    input  logic [((VALUE_WIDTH+i2rd_pkg::BASE_W+7)/8)*8-1:0] i_s_tdata,
    // output word: [6:0] digit_char, [7] zero pad
    output logic                                          o_m_tvalid,
    input  logic                                          i_m_tready,
    output logic [7:0]                                    o_m_tdata,
    // last_digit
    output logic                                          o_m_tlast
);
    import i2rd_pkg::*;

    // Dividend is padded to whole bytes so every divide cycle retires one byte.
    localparam int PAD_W  = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int NSTEP  = PAD_W / STEP_BITS;
    localparam int STEP_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W  = $clog2(MAX_DIGITS);

    t_state r_state, n_state;

    logic [PAD_W-1:0]   r_div,  n_div;    // dividend in, quotient shifts in from below
    logic [DIGIT_W-1:0] r_rem,  n_rem;    // running remainder
    logic [BASE_W-1:0]  r_base, n_base;   // saturated radix
    logic [STEP_W-1:0]  r_step, n_step;   // byte position within one division
    logic [CNT_W-1:0]   r_cnt,  n_cnt;    // digits produced so far
    logic [IDX_W-1:0]   r_idx,  n_idx;    // digit being emitted, MS first

    logic               r_ovalid, n_ovalid;
    logic [CHAR_W-1:0]  r_ochar,  n_ochar;
    logic               r_olast,  n_olast;

    // digit store, LS digit at entry 0
    logic [DIGIT_W-1:0] r_store [MAX_DIGITS];
    logic [DIGIT_W-1:0] r_rd;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;

    // shared divide step
    logic [BASE_W-1:0]    in_base, base_sat;
    logic [BASE_W-1:0]    trial;
    logic [DIGIT_W-1:0]   rem_t;
    logic [STEP_BITS-1:0] q_byte;
    logic [PAD_W-1:0]     quot_next;
    logic [CNT_W-1:0]     cnt_inc;

    assign in_base = i_s_tdata[VALUE_WIDTH +: BASE_W];

    always_comb begin
        priority if (in_base < BASE_MIN) begin
            base_sat = BASE_MIN;
        end else if (in_base > BASE_MAX) begin
            base_sat = BASE_MAX;
        end else begin
            base_sat = in_base;
        end
    end

    // Eight restoring steps on the top dividend byte; remainder stays below base.
    always_comb begin
        rem_t  = r_rem;
        q_byte = '0;
        trial  = '0;
        for (int j = 0; j < STEP_BITS; j++) begin
            trial = {rem_t, r_div[PAD_W-1-j]};
            if (trial >= r_base) begin
                trial = trial - r_base;
                q_byte[STEP_BITS-1-j] = 1'b1;
            end
            rem_t = trial[DIGIT_W-1:0];
        end
    end

    assign quot_next = (r_div << STEP_BITS) | PAD_W'(q_byte);
    assign cnt_inc   = r_cnt + CNT_W'(1);

    // next state and outputs
    always_comb begin
        n_state  = r_state;
        n_div    = r_div;
        n_rem    = r_rem;
        n_base   = r_base;
        n_step   = r_step;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_ovalid = r_ovalid;
        n_ochar  = r_ochar;
        n_olast  = r_olast;
        wr_en    = 1'b0;
        wr_addr  = r_cnt[IDX_W-1:0];
        o_s_tready = (r_state == ST_IDLE);

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_div   = PAD_W'(i_s_tdata[VALUE_WIDTH-1:0]);
                    n_base  = base_sat;
                    n_rem   = '0;
                    n_step  = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_div  = quot_next;
                n_rem  = rem_t;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(NSTEP - 1)) begin
                    // division done: keep the remainder as the next digit
                    wr_en  = 1'b1;
                    n_cnt  = cnt_inc;
                    n_rem  = '0;
                    n_step = '0;
                    // a zero value still yields one digit, as the loop runs once
                    if (quot_next == '0 || cnt_inc >= CNT_W'(MAX_DIGITS)) begin
                        n_idx   = r_cnt[IDX_W-1:0];
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_ochar  = digit_to_ascii(r_rd);
                    n_olast  = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx - IDX_W'(1);
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_step   <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
            r_div    <= '0;
            r_base   <= BASE_MIN;
            r_rem    <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_step   <= n_step;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
            r_div    <= n_div;
            r_base   <= n_base;
            r_rem    <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ochar <= n_ochar;
        r_olast <= n_olast;
    end

    // digit store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= rem_t;
        end
        r_rd <= r_store[r_idx];
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_ochar};
    assign o_m_tlast  = r_olast;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_DIGITS))
        else $error("digit count past store depth");

    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_base >= BASE_MIN && r_base <= BASE_MAX))
        else $error("radix out of range while busy");

    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (CNT_W'(r_rem) < CNT_W'(r_base)))
        else $error("remainder not below radix");

    a_idx_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ || r_state == ST_LOAD) |-> (CNT_W'(r_idx) < r_cnt))
        else $error("emit index beyond produced digits");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD && (!r_ovalid || i_m_tready) && r_idx == '0)
        |=> (r_state == ST_IDLE && o_m_tlast && o_m_tvalid))
        else $error("final digit did not close the run");
`endif

endmodule

[test/tb_top.sv]
// Testbench for integer_to_radix_digits: directed table plus random values, checked per digit.
`timescale 1ns / 100ps

module tb_top;

    import i2rd_pkg::*;

    localparam int VALUE_W    = 32;
    localparam int IN_W       = ((VALUE_W + BASE_W + 7) / 8) * 8;
    localparam int MAX_DIGS   = 32;
    localparam int RAND_WORDS = 185;
    localparam int CALM_FROM  = 160;    // random words from here on run without idling
    localparam int HOLD_AFTER = 40;     // words sent before the long output hold-off
    localparam int HOLD_LEN   = 400;    // length of that hold-off
    localparam int DRAIN_LEN  = 200;    // wait after the last expected digit, to catch any stray output
    localparam int STALL_MAX  = 4000;   // watchdog limit while no word moves on either side

    // One expected output word.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_digit_exp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // input word: [31:0] value, [36:32] base, [39:37] zero pad
    logic            i_s_tvalid = 1'b0;
    logic            o_s_tready;
    logic [IN_W-1:0] i_s_tdata = '0;
    // output word: [6:0] digit_char, [7] zero pad
    logic            o_m_tvalid;
    logic            i_m_tready = 1'b0;
    logic [7:0]      o_m_tdata;
    // last_digit
    logic            o_m_tlast;

    t_digit_exp pending_digits[$];      // digits still owed by the block, oldest first
    logic [VALUE_W-1:0] row_value[$];   // directed table
    logic [BASE_W-1:0]  row_base[$];
    string              row_text[$];    // "" means: use the digit predictor

    int  fail_count = 0;
    int  words_sent = 0;
    int  idle_cycles = 0;
    logic calm = 1'b0;

    always #5 i_clk = ~i_clk;

    integer_to_radix_digits #(
        .VALUE_WIDTH(VALUE_W),
        .MAX_DIGITS (MAX_DIGS)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast)
    );

    // Divide-and-remainder predictor: queues the digits of value in the
    // saturated radix, most significant first.
    function automatic void predict_digits(input logic [VALUE_W-1:0] value,
                                           input logic [BASE_W-1:0] base);
        logic [VALUE_W-1:0] rest;
        logic [VALUE_W-1:0] radix;
        logic [3:0]         rems[MAX_DIGS];
        int                 n;
        t_digit_exp         exp_word;
        // out-of-range radix clamps to 2..16
        if (base < BASE_MIN) begin
            radix = VALUE_W'(BASE_MIN);
        end else if (base > BASE_MAX) begin
            radix = VALUE_W'(BASE_MAX);
        end else begin
            radix = VALUE_W'(base);
        end
        rest = value;
        n = 0;
        if (rest == '0) begin
            rems[0] = 4'd0;     // zero still gives one digit
            n = 1;
        end else begin
            while (rest != '0 && n < MAX_DIGS) begin
                rems[n] = 4'(rest % radix);
                rest = rest / radix;
                n++;
            end
        end
        for (int k = n - 1; k >= 0; k--) begin
            if (rems[k] < 4'd10) begin
                exp_word.ch = 7'd48 + CHAR_W'(rems[k]);
            end else begin
                exp_word.ch = 7'd55 + CHAR_W'(rems[k]);
            end
            exp_word.last = (k == 0);
            pending_digits.push_back(exp_word);
        end
    endfunction

    task automatic add_row(input logic [VALUE_W-1:0] value, input logic [BASE_W-1:0] base,
                           input string text);
        row_value.push_back(value);
        row_base.push_back(base);
        row_text.push_back(text);
    endtask

    // Offer one word, wait for the handshake, then queue what it must produce.
    task automatic send_word(input logic [VALUE_W-1:0] value, input logic [BASE_W-1:0] base,
                             input string text);
        t_digit_exp exp_word;
        byte        ch_b;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_W - VALUE_W - BASE_W){1'b0}}, base, value};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (text.len() == 0) begin
            predict_digits(value, base);
        end else begin
            for (int i = 0; i < text.len(); i++) begin
                ch_b = text[i];
                exp_word.ch = ch_b[CHAR_W-1:0];
                exp_word.last = (i == text.len() - 1);
                pending_digits.push_back(exp_word);
            end
        end
        words_sent++;
        @(negedge i_clk);
        // random gap; valid stays high straight into the next word otherwise
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
    endtask

    // Output side: random hold-offs, one long one to back the block up.
    initial begin
        logic held;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && words_sent >= HOLD_AFTER) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                for (int c = 1; c < HOLD_LEN; c++) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Digit checker.
    always @(posedge i_clk) begin
        t_digit_exp exp_word;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_digits.size() == 0) begin
                $error("unexpected digit: digit_char %0d last_digit %0b",
                       o_m_tdata[CHAR_W-1:0], o_m_tlast);
                fail_count++;
            end else begin
                exp_word = pending_digits.pop_front();
                if (o_m_tdata[CHAR_W-1:0] !== exp_word.ch) begin
                    $error("digit_char: expected %0d, got %0d",
                           exp_word.ch, o_m_tdata[CHAR_W-1:0]);
                    fail_count++;
                end
                if (o_m_tlast !== exp_word.last) begin
                    $error("last_digit: expected %0b, got %0b", exp_word.last, o_m_tlast);
                    fail_count++;
                end
                if (o_m_tdata[7] !== 1'b0) begin
                    $error("pad: expected 0, got %0b", o_m_tdata[7]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: no word moving on either side for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_MAX) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [VALUE_W-1:0] value;
        logic [BASE_W-1:0]  base;
        int                 pick;

        // Directed rows: expected text typed in where obvious.
        add_row(32'd0,          5'd10, "0");
        add_row(32'd0,          5'd0,  "0");            // zero with radix below range
        add_row(32'd0,          5'd31, "0");            // zero with radix above range
        add_row(32'd1,          5'd2,  "1");
        add_row(32'hFFFF_FFFF,  5'd16, "FFFFFFFF");
        add_row(32'hFFFF_FFFF,  5'd2,  {"1111111111111111", "1111111111111111"});
        add_row(32'hFFFF_FFFF,  5'd10, "4294967295");
        add_row(32'hFFFF_FFFF,  5'd0,  "");             // clamps to binary, 32 digits
        add_row(32'd5,          5'd1,  "101");          // radix 1 clamps to 2
        add_row(32'd255,        5'd17, "FF");           // radix 17 clamps to 16
        add_row(32'd255,        5'd31, "FF");
        add_row(32'd16,         5'd16, "10");
        add_row(32'd15,         5'd16, "F");
        add_row(32'd10,         5'd16, "A");
        add_row(32'd9,          5'd10, "9");
        add_row(32'd7,          5'd8,  "7");
        add_row(32'd8,          5'd8,  "10");
        add_row(32'd1000,       5'd10, "1000");
        add_row(32'h1234_5678,  5'd16, "12345678");
        add_row(32'hDEAD_BEEF,  5'd16, "DEADBEEF");
        add_row(32'h8000_0000,  5'd2,  "");
        add_row(32'd35,         5'd3,  "");
        add_row(32'd123456789,  5'd7,  "");
        add_row(32'hFFFF_FFFF,  5'd3,  "");
        add_row(32'hAAAA_AAAA,  5'd5,  "");

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < row_value.size(); r++) begin
            send_word(row_value[r], row_base[r], row_text[r]);
        end

        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n >= CALM_FROM) calm = 1'b1;
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                value = '0;
            end else if (pick <= 6) begin
                value = VALUE_W'($urandom_range(1, 255));   // short digit runs
            end else if (pick <= 8) begin
                value = ~VALUE_W'($urandom_range(0, 15));   // near the top
            end else begin
                value = $urandom;
            end
            // mostly legal radices, sometimes anything the field holds
            if ($urandom_range(0, 4) == 0) begin
                base = BASE_W'($urandom_range(0, 31));
            end else begin
                base = BASE_W'($urandom_range(2, 16));
            end
            send_word(value, base, "");
        end
        i_s_tvalid <= 1'b0;

        while (pending_digits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_LEN) @(posedge i_clk);

        if (fail_count == 0 && pending_digits.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/i2rd_pkg.sv
rtl/core/integer_to_radix_digits.sv
test/tb_top.sv
